/* sv/b32enc_pkg.sv */
// Shared constants and helpers for the bech32 / bech32m segwit address encoder.
// Holds the default sizes, the charset table and the BCH polymod step.
// Depends on nothing; used by bech32_segwit_address_encoder.
package b32enc_pkg;

  localparam int PART_MAX_DEF    = 83;
  localparam int PROGRAM_MAX_DEF = 40;
  localparam int SYMBOL_MAX_DEF  = 65;
  localparam int CPR_DEF         = 8;
  localparam int RESULT_LIMIT    = 20;

  localparam logic [29:0] CHK_INIT     = 30'd1;
  localparam logic [29:0] CONST_BECH32 = 30'd1;
  localparam logic [29:0] CONST_BECH32M = 30'h2bc830a3;
  localparam logic [7:0]  SEP_CHAR     = 8'h31;
  localparam logic [7:0]  MAX_VERSION  = 8'd16;

  // Error codes carried in a result.
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_VERSION  = 3'd1;
  localparam logic [2:0] ERR_PROG_LEN = 3'd2;
  localparam logic [2:0] ERR_PART_LEN = 3'd3;
  localparam logic [2:0] ERR_CAPACITY = 3'd4;
  localparam logic [2:0] ERR_PART_CHR = 3'd5;

  // Bech32 data charset, indexed by symbol value.
  localparam logic [7:0] CHARSET [32] = '{
    "q", "p", "z", "r", "y", "9", "x", "8",
    "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h",
    "c", "e", "6", "m", "u", "a", "7", "l"
  };

  // One step of the BCH polymod: shift in a zero symbol and fold the top back.
  function automatic logic [29:0] bch_step(input logic [29:0] v);
    logic [4:0]  top;
    logic [29:0] r;
    top = v[29:25];
    r   = {v[24:0], 5'd0};
    if (top[0]) r = r ^ 30'h3b6a57b2;
    if (top[1]) r = r ^ 30'h26508e6d;
    if (top[2]) r = r ^ 30'h1ea119fa;
    if (top[3]) r = r ^ 30'h3d4233dd;
    if (top[4]) r = r ^ 30'h2a1462b3;
    return r;
  endfunction

endpackage

/* sv/bech32_segwit_address_encoder.sv */
// Bech32 / bech32m segwit address encoder: top level with part and symbol memories.
// Depends on b32enc_pkg for sizes, charset and the polymod step.
//
// Part characters and program bytes are loaded one transaction per cycle, except that a
// program byte which yields two 5-bit symbols holds input for a second write state (one
// symbol memory write port). The item with tlast closes the address: a padding state and
// a check state, then the checksum walk over both memories, one polymod step per cycle
// (2*part + symbols + 8 steps), then the emission walk, one character per cycle while the
// output is not stalled (part + symbols + 8), with a result of up to CHARS_PER_RESULT
// characters handed out as each fills. Input is not taken until the address has been
// emitted or its error result loaded. An error gives a single result.
module bech32_segwit_address_encoder #(
  parameter int PART_MAX         = b32enc_pkg::PART_MAX_DEF,
  parameter int PROGRAM_MAX      = b32enc_pkg::PROGRAM_MAX_DEF,
  parameter int SYMBOL_MAX       = b32enc_pkg::SYMBOL_MAX_DEF,
  parameter int CHARS_PER_RESULT = b32enc_pkg::CPR_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,     // out_capacity
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,       // item_byte[7:0], witness_version[15:8]
  input  logic        s_tuser,       // req_type
  input  logic        s_tlast,       // last_item
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,       // out_chars[63:0], char_count[67:64], error_code[70:68]
  output logic        m_tlast        // last_out
);

  localparam int PC_W = $clog2(PART_MAX + 2);
  localparam int PG_W = $clog2(PROGRAM_MAX + 2);
  localparam int SC_W = $clog2(SYMBOL_MAX + 1);
  localparam int PA_W = (PART_MAX > 1) ? $clog2(PART_MAX) : 1;
  localparam int SA_W = $clog2(SYMBOL_MAX);
  localparam int IX_W = (PC_W > SC_W) ? PC_W : SC_W;
  localparam int T_W  = $clog2(PART_MAX + SYMBOL_MAX + 10);

  typedef enum logic [2:0] {S_LOAD, S_SECOND, S_CLOSE, S_DECIDE, S_WALK} state_t;
  typedef enum logic [2:0] {PH_HI, PH_SEP, PH_LO, PH_SYM, PH_TAIL} phase_t;

  state_t state;
  phase_t ph, tag_ph;

  logic [7:0]      out_capacity;
  logic [PC_W-1:0] part_count;
  logic [SC_W-1:0] sym_count;
  logic [PG_W-1:0] prog_count;
  logic [3:0]      acc;
  logic [3:0]      pend;
  logic            bad_char;
  logic [29:0]     chk;
  logic [7:0]      ver;
  logic            ver_zero;
  logic            closing;
  logic [4:0]      sym2;

  logic [IX_W-1:0] idx;
  logic [IX_W-1:0] tag_idx;
  logic            issue_on;
  logic            tag_v;
  logic            emit;
  logic [63:0]     word;
  logic [3:0]      wc;

  // Memories and their registered read data.
  logic [6:0] part_mem [PART_MAX];
  logic [4:0] sym_mem  [SYMBOL_MAX];
  logic [6:0] part_rd;
  logic [4:0] sym_rd;

  logic            sym_we;
  logic [SA_W-1:0] sym_wa;
  logic [4:0]      sym_wd;

  // Input side decode.
  logic        acc_in;
  logic [7:0]  in_byte;
  logic [11:0] acc12;
  logic [3:0]  pb1, pb2;
  logic [4:0]  s1, s2;
  logic        two_sym;
  logic        prog_take;
  logic        push_ok;

  assign s_tready = (state == S_LOAD);
  assign acc_in   = s_tvalid && s_tready;
  assign in_byte  = s_tdata[7:0];
  assign acc12    = {acc, in_byte};
  assign pb1      = pend + 4'd3;
  assign two_sym  = (pb1 >= 4'd5);
  assign pb2      = pb1 - 4'd5;
  assign s1       = 5'(acc12 >> pb1);
  assign s2       = 5'(acc12 >> pb2);
  assign prog_take = (32'(prog_count) < PROGRAM_MAX);
  assign push_ok   = (32'(sym_count) + 1 < SYMBOL_MAX);

  // Closing checks.
  logic [T_W:0] total;
  logic [2:0]   err;
  logic [8:0]   pad_tmp;
  assign total   = (T_W+1)'(part_count) + (T_W+1)'(sym_count) + (T_W+1)'(8);
  assign pad_tmp = {5'd0, acc} << (4'd5 - pend);

  always_comb begin
    if (ver > b32enc_pkg::MAX_VERSION) begin
      err = b32enc_pkg::ERR_VERSION;
    end else if (prog_count < PG_W'(2) || 32'(prog_count) > PROGRAM_MAX) begin
      err = b32enc_pkg::ERR_PROG_LEN;
    end else if (part_count == '0 || 32'(part_count) > PART_MAX) begin
      err = b32enc_pkg::ERR_PART_LEN;
    end else if (32'(total) + 1 > 32'(out_capacity) ||
                 32'(total) > b32enc_pkg::RESULT_LIMIT * CHARS_PER_RESULT) begin
      err = b32enc_pkg::ERR_CAPACITY;
    end else if (bad_char) begin
      err = b32enc_pkg::ERR_PART_CHR;
    end else begin
      err = b32enc_pkg::ERR_NONE;
    end
  end

  // Symbol memory write port selection.
  always_comb begin
    sym_we = 1'b0;
    sym_wa = SA_W'(32'(sym_count) + 1);
    sym_wd = s1;
    unique case (state)
      S_LOAD:   sym_we = acc_in && s_tuser && prog_take && push_ok;
      S_SECOND: begin
        sym_we = push_ok;
        sym_wd = sym2;
      end
      S_CLOSE:  begin
        sym_we = (pend != 4'd0) && push_ok;
        sym_wd = pad_tmp[4:0];
      end
      S_DECIDE: begin
        sym_we = (err == b32enc_pkg::ERR_NONE);
        sym_wa = '0;
        sym_wd = ver[4:0];
      end
      default:  sym_we = 1'b0;
    endcase
  end

  // Walk control.
  logic out_free, stall, do_issue, do_cons, fin_tail;
  logic [IX_W-1:0] ph_end;
  assign out_free = !m_tvalid || m_tready;
  assign stall    = emit && !out_free;
  assign do_issue = (state == S_WALK) && issue_on && !stall;
  assign do_cons  = (state == S_WALK) && tag_v && !stall;
  assign fin_tail = (tag_ph == PH_TAIL) && (tag_idx == IX_W'(5));

  // A result is loaded this cycle: an error, a filled group of characters, or the last group.
  logic m_load;
  assign m_load = ((state == S_DECIDE) && (err != b32enc_pkg::ERR_NONE) && out_free) ||
                  (do_cons && emit && (fin_tail || 32'(wc) + 1 == CHARS_PER_RESULT));

  always_comb begin
    unique case (ph)
      PH_HI, PH_LO: ph_end = IX_W'(part_count) - IX_W'(1);
      PH_SYM:       ph_end = IX_W'(sym_count);
      PH_TAIL:      ph_end = IX_W'(5);
      default:      ph_end = '0;
    endcase
  end

  // Value folded in at each consumed step, and the emitted character.
  logic [4:0] tail_sym;
  logic [4:0] fold;
  logic [7:0] ch;
  always_comb begin
    unique case (tag_idx[2:0])
      3'd0:    tail_sym = chk[29:25];
      3'd1:    tail_sym = chk[24:20];
      3'd2:    tail_sym = chk[19:15];
      3'd3:    tail_sym = chk[14:10];
      3'd4:    tail_sym = chk[9:5];
      default: tail_sym = chk[4:0];
    endcase
    unique case (tag_ph)
      PH_HI:   fold = {3'd0, part_rd[6:5]};
      PH_LO:   fold = part_rd[4:0];
      PH_SYM:  fold = sym_rd;
      default: fold = 5'd0;
    endcase
    unique case (tag_ph)
      PH_LO:   ch = {1'b0, part_rd};
      PH_SYM:  ch = b32enc_pkg::CHARSET[sym_rd];
      PH_TAIL: ch = b32enc_pkg::CHARSET[tail_sym];
      default: ch = b32enc_pkg::SEP_CHAR;
    endcase
  end

  logic [63:0] word_next;
  always_comb begin
    word_next = word;
    word_next[{wc[2:0], 3'b000} +: 8] = ch;
  end

  // Memory writes and registered reads.
  always_ff @(posedge clk) begin
    if (acc_in && !s_tuser && 32'(part_count) < PART_MAX) begin
      part_mem[PA_W'(part_count)] <= in_byte[6:0];
    end
    if (sym_we) begin
      sym_mem[sym_wa] <= sym_wd;
    end
    if (do_issue && (ph == PH_HI || ph == PH_LO)) begin
      part_rd <= part_mem[idx[PA_W-1:0]];
    end
    if (do_issue && ph == PH_SYM) begin
      sym_rd <= sym_mem[idx[SA_W-1:0]];
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= 8'd255;
    end else if (cfg_we) begin
      out_capacity <= cfg_wdata;
    end
  end

  // Main sequencer: loading, closing checks, checksum walk and emission.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      part_count <= '0;
      sym_count  <= '0;
      prog_count <= '0;
      acc        <= '0;
      pend       <= '0;
      bad_char   <= 1'b0;
      chk        <= b32enc_pkg::CHK_INIT;
      closing    <= 1'b0;
      issue_on   <= 1'b0;
      tag_v      <= 1'b0;
      emit       <= 1'b0;
      wc         <= '0;
      word       <= '0;
      m_tvalid   <= 1'b0;
      ph         <= PH_HI;
      tag_ph     <= PH_HI;
      idx        <= '0;
      tag_idx    <= '0;
    end else begin
      if (m_tvalid && m_tready && !m_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_LOAD: begin
          if (acc_in) begin
            closing <= s_tlast;
            ver     <= s_tdata[15:8];
            if (!s_tuser) begin
              if (in_byte < 8'd33 || in_byte > 8'd126 ||
                  (in_byte >= "A" && in_byte <= "Z")) begin
                bad_char <= 1'b1;
              end
              if (32'(part_count) <= PART_MAX) part_count <= part_count + PC_W'(1);
              state <= s_tlast ? S_CLOSE : S_LOAD;
            end else begin
              if (prog_take) begin
                acc  <= acc12[3:0];
                pend <= two_sym ? pb2 : pb1;
                sym2 <= s2;
                if (push_ok) sym_count <= sym_count + SC_W'(1);
              end
              if (32'(prog_count) <= PROGRAM_MAX) prog_count <= prog_count + PG_W'(1);
              if (prog_take && two_sym) begin
                state <= S_SECOND;
              end else begin
                state <= s_tlast ? S_CLOSE : S_LOAD;
              end
            end
          end
        end
        S_SECOND: begin
          if (push_ok) sym_count <= sym_count + SC_W'(1);
          state <= closing ? S_CLOSE : S_LOAD;
        end
        S_CLOSE: begin
          if (pend != 4'd0) begin
            if (push_ok) sym_count <= sym_count + SC_W'(1);
            pend <= '0;
          end
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          ver_zero <= (ver == 8'd0);
          if (err != b32enc_pkg::ERR_NONE) begin
            if (out_free) begin
              m_tvalid <= 1'b1;
              m_tdata  <= {1'b0, err, 4'd0, 64'd0};
              m_tlast  <= 1'b1;
              part_count <= '0;
              sym_count  <= '0;
              prog_count <= '0;
              acc        <= '0;
              pend       <= '0;
              bad_char   <= 1'b0;
              state      <= S_LOAD;
            end
          end else begin
            chk      <= b32enc_pkg::CHK_INIT;
            ph       <= PH_HI;
            idx      <= '0;
            issue_on <= 1'b1;
            emit     <= 1'b0;
            tag_v    <= 1'b0;
            wc       <= '0;
            word     <= '0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          // Issue side: step through the phases, one read per cycle unless the output stalls.
          if (!stall) begin
            tag_v   <= do_issue;
            tag_ph  <= ph;
            tag_idx <= idx;
          end
          if (do_issue) begin
            if (ph == PH_SEP) begin
              ph  <= emit ? PH_SYM : PH_LO;
              idx <= '0;
            end else if (idx == ph_end) begin
              idx <= '0;
              unique case (ph)
                PH_HI:   ph <= PH_SEP;
                PH_LO:   ph <= emit ? PH_SEP : PH_SYM;
                PH_SYM:  ph <= PH_TAIL;
                default: issue_on <= 1'b0;
              endcase
            end else begin
              idx <= idx + IX_W'(1);
            end
          end
          // Consume side: fold into the checksum or place the character.
          if (do_cons) begin
            if (!emit) begin
              if (fin_tail) begin
                chk <= b32enc_pkg::bch_step(chk) ^
                       (ver_zero ? b32enc_pkg::CONST_BECH32 : b32enc_pkg::CONST_BECH32M);
                emit     <= 1'b1;
                ph       <= PH_LO;
                idx      <= '0;
                issue_on <= 1'b1;
              end else begin
                chk <= b32enc_pkg::bch_step(chk) ^ {25'd0, fold};
              end
            end else begin
              if (fin_tail || 32'(wc) + 1 == CHARS_PER_RESULT) begin
                m_tvalid <= 1'b1;
                m_tdata  <= {1'b0, b32enc_pkg::ERR_NONE, wc + 4'd1, word_next};
                m_tlast  <= fin_tail;
                word     <= '0;
                wc       <= '0;
              end else begin
                word <= word_next;
                wc   <= wc + 4'd1;
              end
              // The issue side is already idle here, so no step is in flight.
              if (fin_tail) begin
                part_count <= '0;
                sym_count  <= '0;
                prog_count <= '0;
                acc        <= '0;
                pend       <= '0;
                bad_char   <= 1'b0;
                chk        <= b32enc_pkg::CHK_INIT;
                emit       <= 1'b0;
                state      <= S_LOAD;
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

/* sim/tb_bech32_segwit_address_encoder.sv */
// Testbench for bech32_segwit_address_encoder: drives part and program transactions,
// predicts the encoded address results and checks them field by field.
// Depends on b32enc_pkg and the encoder RTL.
module tb_bech32_segwit_address_encoder;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] version;
    logic       closes;
  } addr_item_t;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  count;
    logic        final_word;
    logic [2:0]  code;
  } addr_word_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [71:0] m_tdata;
  logic        m_tlast;

  bech32_segwit_address_encoder DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  localparam logic [7:0] ALPHABET [32] = '{
    "q", "p", "z", "r", "y", "9", "x", "8", "g", "f", "2", "t", "v", "d", "w", "0",
    "s", "3", "j", "n", "5", "4", "k", "h", "c", "e", "6", "m", "u", "a", "7", "l"
  };

  // Predictor state for the address being assembled.
  logic [7:0]  capacity;
  logic [6:0]  hrp_chars [b32enc_pkg::PART_MAX_DEF];
  int          hrp_len;
  logic [4:0]  sym_mem [b32enc_pkg::SYMBOL_MAX_DEF];
  int          sym_len;
  int          byte_total;
  logic [11:0] acc;
  int          acc_bits;
  bit          hrp_bad;

  addr_item_t  pending_items [$];
  addr_word_t  expected_words [$];
  int          error_count;
  int          send_idle_pct;
  int          recv_stall_pct;

  function automatic logic [29:0] polymod(logic [29:0] v);
    logic [29:0] r;
    r = {v[24:0], 5'd0};
    if (v[25]) r ^= 30'h3b6a57b2;
    if (v[26]) r ^= 30'h26508e6d;
    if (v[27]) r ^= 30'h1ea119fa;
    if (v[28]) r ^= 30'h3d4233dd;
    if (v[29]) r ^= 30'h2a1462b3;
    return r;
  endfunction

  task automatic clear_address();
    hrp_len = 0; sym_len = 0; byte_total = 0; acc = '0; acc_bits = 0; hrp_bad = 0;
  endtask

  function automatic void push_sym(logic [4:0] s);
    if (sym_len + 1 < b32enc_pkg::SYMBOL_MAX_DEF) begin
      sym_mem[sym_len + 1] = s;
      sym_len++;
    end
  endfunction

  function automatic void push_error(logic [2:0] code);
    addr_word_t w;
    w = '{chars: '0, count: '0, final_word: 1'b1, code: code};
    expected_words.push_back(w);
  endfunction

  // Absorb one accepted item and queue the results it causes.
  task automatic encode_item(addr_item_t it);
    logic [29:0] chk;
    logic [7:0]  text [200];
    int          dn, total, nres, cnt;
    addr_word_t  w;
    if (!it.kind) begin
      if (it.data_byte < 33 || it.data_byte > 126 ||
          (it.data_byte >= "A" && it.data_byte <= "Z")) hrp_bad = 1;
      if (hrp_len < b32enc_pkg::PART_MAX_DEF) hrp_chars[hrp_len] = it.data_byte[6:0];
      if (hrp_len <= b32enc_pkg::PART_MAX_DEF) hrp_len++;
    end else begin
      if (byte_total < b32enc_pkg::PROGRAM_MAX_DEF) begin
        acc = {acc[3:0], it.data_byte};
        acc_bits += 8;
        while (acc_bits >= 5) begin
          acc_bits -= 5;
          push_sym(5'((acc >> acc_bits) & 12'h1f));
        end
        acc = acc & 12'hf;
      end
      if (byte_total <= b32enc_pkg::PROGRAM_MAX_DEF) byte_total++;
    end
    if (!it.closes) return;
    if (it.version > b32enc_pkg::MAX_VERSION) begin
      push_error(b32enc_pkg::ERR_VERSION); clear_address(); return;
    end
    if (byte_total < 2 || byte_total > b32enc_pkg::PROGRAM_MAX_DEF) begin
      push_error(b32enc_pkg::ERR_PROG_LEN); clear_address(); return;
    end
    if (acc_bits > 0) begin
      push_sym(5'((acc << (5 - acc_bits)) & 12'h1f));
      acc_bits = 0;
    end
    if (hrp_len < 1 || hrp_len > b32enc_pkg::PART_MAX_DEF) begin
      push_error(b32enc_pkg::ERR_PART_LEN); clear_address(); return;
    end
    dn = 1 + sym_len;
    total = hrp_len + 1 + dn + 6;
    nres = (total + 7) / 8;
    if (total + 1 > int'(capacity) || nres > b32enc_pkg::RESULT_LIMIT) begin
      push_error(b32enc_pkg::ERR_CAPACITY); clear_address(); return;
    end
    if (hrp_bad) begin
      push_error(b32enc_pkg::ERR_PART_CHR); clear_address(); return;
    end
    sym_mem[0] = it.version[4:0];
    // Polymod over the expanded part, the data and six zero symbols.
    chk = 30'd1;
    for (int i = 0; i < hrp_len; i++) chk = polymod(chk) ^ 30'(hrp_chars[i] >> 5);
    chk = polymod(chk);
    for (int i = 0; i < hrp_len; i++) chk = polymod(chk) ^ 30'(hrp_chars[i] & 7'h1f);
    for (int i = 0; i < dn; i++) chk = polymod(chk) ^ 30'(sym_mem[i]);
    for (int i = 0; i < 6; i++) chk = polymod(chk);
    chk ^= (it.version == 0) ? b32enc_pkg::CONST_BECH32 : b32enc_pkg::CONST_BECH32M;
    for (int i = 0; i < hrp_len; i++) text[i] = {1'b0, hrp_chars[i]};
    text[hrp_len] = "1";
    for (int i = 0; i < dn; i++) text[hrp_len + 1 + i] = ALPHABET[sym_mem[i]];
    for (int i = 0; i < 6; i++)
      text[hrp_len + 1 + dn + i] = ALPHABET[5'(chk >> (5 * (5 - i)))];
    for (int k = 0; k < nres; k++) begin
      cnt = total - 8 * k;
      if (cnt > 8) cnt = 8;
      w.chars = '0;
      for (int i = 0; i < cnt; i++) w.chars[8 * i +: 8] = text[8 * k + i];
      w.count = 4'(cnt);
      w.final_word = (k + 1 == nres);
      w.code = b32enc_pkg::ERR_NONE;
      expected_words.push_back(w);
    end
    clear_address();
  endtask

  // Queue one address: part characters then program bytes, last one closing.
  task automatic queue_address(int plen, int blen, logic [7:0] ver, bit clean_part);
    addr_item_t it;
    int n;
    n = plen + blen;
    for (int i = 0; i < n; i++) begin
      it.kind = (i >= plen);
      if (it.kind) it.data_byte = 8'($urandom);
      else if (clean_part) it.data_byte = 8'($urandom_range(33, 64));
      else it.data_byte = 8'($urandom);
      if (!it.kind && clean_part && $urandom_range(0, 1))
        it.data_byte = 8'($urandom_range(91, 126));
      it.version = (i == n - 1) ? ver : 8'($urandom);
      it.closes = (i == n - 1);
      pending_items.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  task automatic write_capacity(logic [7:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    capacity = value;
  endtask

  // Clock generator.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Driver: presents the head of the pending queue and retires it on acceptance.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        encode_item(pending_items.pop_front());
      end
      if ((!s_tvalid || s_tready) && pending_items.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tuser <= pending_items[0].kind;
        s_tdata <= {pending_items[0].version, pending_items[0].data_byte};
        s_tlast <= pending_items[0].closes;
      end else if (!s_tvalid || s_tready) begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compares each result transaction with the oldest expectation.
  always @(posedge clk) begin
    addr_word_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected result transaction %h", m_tdata);
          error_count++;
        end else begin
          w = expected_words.pop_front();
          if (m_tdata[63:0] !== w.chars) begin
            $error("out_chars expected %h actual %h", w.chars, m_tdata[63:0]);
            error_count++;
          end
          if (m_tdata[67:64] !== w.count) begin
            $error("char_count expected %0d actual %0d", w.count, m_tdata[67:64]);
            error_count++;
          end
          if (m_tdata[70:68] !== w.code) begin
            $error("error_code expected %0d actual %0d", w.code, m_tdata[70:68]);
            error_count++;
          end
          if (m_tlast !== w.final_word) begin
            $error("last_out expected %0d actual %0d", w.final_word, m_tlast);
            error_count++;
          end
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  initial begin
    #30000000;
    $display("tb_bech32_segwit_address_encoder: errors");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int plen;
    rst = 1'b1; cfg_we = 1'b0; cfg_wdata = '0; s_tvalid = 1'b0; s_tdata = '0;
    s_tuser = 1'b0; s_tlast = 1'b0; m_tready = 1'b0;
    error_count = 0; send_idle_pct = 0; recv_stall_pct = 0;
    capacity = 8'd255;
    clear_address();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: both encodings, each error, extreme bytes and versions.
    queue_address(2, 20, 8'd0, 1);
    queue_address(1, 2, 8'd16, 1);
    queue_address(3, 2, 8'd17, 1);
    queue_address(2, 2, 8'd255, 1);
    queue_address(2, 1, 8'd0, 1);
    queue_address(0, 3, 8'd1, 1);
    queue_address(2, 4, 8'd1, 0);
    wait_drained();
    write_capacity(8'd0);
    queue_address(1, 2, 8'd0, 1);
    wait_drained();
    write_capacity(8'd14);
    queue_address(1, 2, 8'd0, 1);
    queue_address(1, 3, 8'd0, 1);
    wait_drained();
    write_capacity(8'd255);
    queue_address(84, 2, 8'd2, 1);
    queue_address(2, 41, 8'd0, 1);
    queue_address(20, 40, 8'd3, 1);
    wait_drained();

    // Random phases with different idle and stall pressure.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 21 : 59) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 21 : 59) : 0;
      if (ph == 2) write_capacity(8'($urandom_range(20, 80)));
      if (ph == 3) write_capacity(8'd255);
      for (int a = 0; a < 3; a++) begin
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 85) : $urandom_range(1, 6);
        queue_address(plen, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 42)
                      : $urandom_range(2, 12),
                      ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 16)),
                      $urandom_range(0, 7) != 0);
      end
      wait_drained();
    end
    if (error_count == 0) begin
      $display("tb_bech32_segwit_address_encoder: clean");
    end else begin
      $display("tb_bech32_segwit_address_encoder: errors");
    end
    $finish;
  end

endmodule
